FILE: rtl/mrr_pkg.sv
// Shared types, codes and the CRC-16 byte update for the Modbus RTU
// read-holding-registers master. No dependencies.
`default_nettype none

package mrr_pkg;

    // input item kinds
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // result item kinds
    localparam logic [1:0] OUT_TX     = 2'd0;
    localparam logic [1:0] OUT_WORD   = 2'd1;
    localparam logic [1:0] OUT_STATUS = 2'd2;

    // final status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TIMEOUT     = 3'd1;
    localparam logic [2:0] ST_BAD_REQUEST = 3'd2;
    localparam logic [2:0] ST_BYTE_COUNT  = 3'd3;
    localparam logic [2:0] ST_CRC         = 3'd4;
    localparam logic [2:0] ST_SLAVE       = 3'd5;
    localparam logic [2:0] ST_FUNCTION    = 3'd6;
    localparam logic [2:0] ST_EXCEPTION   = 3'd7;

    localparam logic [7:0]  FN_READ     = 8'h03;
    localparam logic [7:0]  SLAVE_MAX   = 8'd247;
    localparam logic [7:0]  COUNT_LIMIT = 8'd250;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_TAIL
    } phase_t;

    typedef enum logic [1:0] {
        CMD_REQ,
        CMD_WORD,
        CMD_STATUS
    } cmd_op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  slave_id;
        logic [15:0] start_address;
        logic [15:0] register_count;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  tx_byte;
        logic [6:0]  reg_index;
        logic [15:0] reg_value;
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic        last;
    } out_item_t;

    // word carries the start address or the register value,
    // index carries the register count or the word index
    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  slave_id;
        logic [15:0] word;
        logic [6:0]  index;
        logic [2:0]  status;
        logic [7:0]  exc;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/modbus_rtu_read_registers_master.sv
// Top level of the Modbus RTU read-holding-registers master: parser front,
// command queue and result sequencer. Depends on mrr_pkg, mrr_front, mrr_queue, mrr_back.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------
//  in       | input     | in_valid / in_ready   | mrr_pkg::in_item_t
//  out      | output    | out_valid / out_ready | mrr_pkg::out_item_t
//
// in_ready drops only while the command queue is full. Each good start emits eight
// request bytes, one per cycle unless the output stalls, from the frame sequencer,
// which sets the rate for starts; words and statuses give one item each. Results
// leave through an output register, so the input side keeps going while a result
// waits. Reset clears the parser phase, queue and output valid.
`default_nettype none

module modbus_rtu_read_registers_master #(
    parameter int MAX_REGISTERS = 125
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mrr_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mrr_pkg::out_item_t      out_item
);

    logic          q_full;
    logic          q_push;
    mrr_pkg::cmd_t q_wdata;
    logic          q_pop;
    logic          q_valid;
    mrr_pkg::cmd_t q_rdata;

    mrr_front #(
        .MAX_REGISTERS(MAX_REGISTERS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (q_wdata)
    );

    mrr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_rdata)
    );

    mrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_rdata),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

FILE: rtl/mrr_front.sv
// Front part: accepts input items, tracks the exchange and parses the response,
// and pushes one command per produced run into the queue. Uses mrr_pkg.
`default_nettype none

module mrr_front #(
    parameter int MAX_REGISTERS = 125
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mrr_pkg::in_item_t in_item,
    input  wire logic             q_full,
    output logic                  push,
    output mrr_pkg::cmd_t         cmd
);

    mrr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  byte_pos_reg, byte_pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  exp_slave_reg, exp_slave_next;
    logic [6:0]  exp_count_reg, exp_count_next;
    logic [7:0]  resp_slave_reg, resp_slave_next;
    logic [7:0]  resp_func_reg, resp_func_next;
    logic [7:0]  resp_count_reg, resp_count_next;
    logic [7:0]  pend_reg, pend_next;
    logic [6:0]  word_idx_reg, word_idx_next;

    logic        fire;
    logic        start_bad;
    logic        is_exc;
    logic [7:0]  dlen;
    logic [8:0]  crc_lo;
    logic [8:0]  pos9;
    logic [15:0] crc_new;
    logic [15:0] rx_crc;
    logic        hdr_overflow;
    logic [2:0]  final_status;
    logic [7:0]  final_exc;

    assign in_ready = !q_full;
    assign fire     = in_valid && !q_full;

    assign start_bad = (in_item.slave_id == 8'd0) || (in_item.slave_id > mrr_pkg::SLAVE_MAX)
                    || (in_item.register_count == 16'd0)
                    || (in_item.register_count > 16'(MAX_REGISTERS));

    assign is_exc  = resp_func_reg[7];
    assign dlen    = is_exc ? 8'd0 : resp_count_reg;
    assign crc_lo  = 9'd3 + {1'b0, dlen};
    assign pos9    = {1'b0, byte_pos_reg};
    assign crc_new = mrr_pkg::crc_byte(crc_reg, in_item.rx_byte);
    assign rx_crc  = {in_item.rx_byte, pend_reg};

    // count byte of a normal header over the limit ends the exchange at once
    assign hdr_overflow = (byte_pos_reg >= 8'd2) && !is_exc
                       && (in_item.rx_byte > mrr_pkg::COUNT_LIMIT);

    always_comb
    begin
        final_exc = 8'd0;
        priority if (rx_crc != crc_reg)
        begin
            final_status = mrr_pkg::ST_CRC;
        end
        else if (resp_slave_reg != exp_slave_reg)
        begin
            final_status = mrr_pkg::ST_SLAVE;
        end
        else if (is_exc)
        begin
            if ({1'b0, resp_func_reg[6:0]} != mrr_pkg::FN_READ)
            begin
                final_status = mrr_pkg::ST_FUNCTION;
            end
            else
            begin
                final_status = mrr_pkg::ST_EXCEPTION;
                final_exc    = resp_count_reg;
            end
        end
        else if (resp_func_reg != mrr_pkg::FN_READ)
        begin
            final_status = mrr_pkg::ST_FUNCTION;
        end
        else if (resp_count_reg != {exp_count_reg, 1'b0})
        begin
            final_status = mrr_pkg::ST_BYTE_COUNT;
        end
        else
        begin
            final_status = mrr_pkg::ST_OK;
        end
    end

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        byte_pos_next   = byte_pos_reg;
        crc_next        = crc_reg;
        exp_slave_next  = exp_slave_reg;
        exp_count_next  = exp_count_reg;
        resp_slave_next = resp_slave_reg;
        resp_func_next  = resp_func_reg;
        resp_count_next = resp_count_reg;
        pend_next       = pend_reg;
        word_idx_next   = word_idx_reg;
        if (fire)
        begin
            unique case (in_item.kind)
                mrr_pkg::KIND_START:
                begin
                    if (start_bad)
                    begin
                        phase_next = mrr_pkg::PH_IDLE;
                    end
                    else
                    begin
                        phase_next      = mrr_pkg::PH_HEADER;
                        exp_slave_next  = in_item.slave_id;
                        exp_count_next  = in_item.register_count[6:0];
                        byte_pos_next   = 8'd0;
                        crc_next        = mrr_pkg::CRC_INIT;
                        resp_slave_next = 8'd0;
                        resp_func_next  = 8'd0;
                        resp_count_next = 8'd0;
                        pend_next       = 8'd0;
                        word_idx_next   = 7'd0;
                    end
                end
                mrr_pkg::KIND_TIMEOUT:
                begin
                    phase_next = mrr_pkg::PH_IDLE;
                end
                mrr_pkg::KIND_BYTE:
                begin
                    unique case (phase_reg)
                        mrr_pkg::PH_HEADER:
                        begin
                            crc_next      = crc_new;
                            byte_pos_next = byte_pos_reg + 8'd1;
                            priority if (byte_pos_reg == 8'd0)
                            begin
                                resp_slave_next = in_item.rx_byte;
                            end
                            else if (byte_pos_reg == 8'd1)
                            begin
                                resp_func_next = in_item.rx_byte;
                            end
                            else
                            begin
                                resp_count_next = in_item.rx_byte;
                            end
                            if (byte_pos_reg >= 8'd2)
                            begin
                                phase_next = hdr_overflow ? mrr_pkg::PH_IDLE : mrr_pkg::PH_TAIL;
                            end
                        end
                        mrr_pkg::PH_TAIL:
                        begin
                            byte_pos_next = byte_pos_reg + 8'd1;
                            priority if (pos9 < crc_lo)
                            begin
                                crc_next = crc_new;
                                // odd position holds the high byte of a word
                                if (byte_pos_reg[0])
                                begin
                                    pend_next = in_item.rx_byte;
                                end
                                else
                                begin
                                    word_idx_next = word_idx_reg + 7'd1;
                                end
                            end
                            else if (pos9 == crc_lo)
                            begin
                                pend_next = in_item.rx_byte;
                            end
                            else
                            begin
                                phase_next = mrr_pkg::PH_IDLE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        push   = 1'b0;
        cmd    = '0;
        cmd.op = mrr_pkg::CMD_STATUS;
        if (fire)
        begin
            unique case (in_item.kind)
                mrr_pkg::KIND_START:
                begin
                    push = 1'b1;
                    if (start_bad)
                    begin
                        cmd.status = mrr_pkg::ST_BAD_REQUEST;
                    end
                    else
                    begin
                        cmd.op       = mrr_pkg::CMD_REQ;
                        cmd.slave_id = in_item.slave_id;
                        cmd.word     = in_item.start_address;
                        cmd.index    = in_item.register_count[6:0];
                    end
                end
                mrr_pkg::KIND_TIMEOUT:
                begin
                    push       = (phase_reg != mrr_pkg::PH_IDLE);
                    cmd.status = mrr_pkg::ST_TIMEOUT;
                end
                mrr_pkg::KIND_BYTE:
                begin
                    unique case (phase_reg)
                        mrr_pkg::PH_HEADER:
                        begin
                            push       = hdr_overflow;
                            cmd.status = mrr_pkg::ST_BYTE_COUNT;
                        end
                        mrr_pkg::PH_TAIL:
                        begin
                            priority if (pos9 < crc_lo)
                            begin
                                if (!byte_pos_reg[0])
                                begin
                                    push      = 1'b1;
                                    cmd.op    = mrr_pkg::CMD_WORD;
                                    cmd.index = word_idx_reg;
                                    cmd.word  = {pend_reg, in_item.rx_byte};
                                end
                            end
                            else if (pos9 > crc_lo)
                            begin
                                push       = 1'b1;
                                cmd.status = final_status;
                                cmd.exc    = final_exc;
                            end
                            else
                            begin
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mrr_pkg::PH_IDLE;
            byte_pos_reg   <= 8'd0;
            crc_reg        <= mrr_pkg::CRC_INIT;
            exp_slave_reg  <= 8'd0;
            exp_count_reg  <= 7'd0;
            resp_slave_reg <= 8'd0;
            resp_func_reg  <= 8'd0;
            resp_count_reg <= 8'd0;
            pend_reg       <= 8'd0;
            word_idx_reg   <= 7'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_pos_reg   <= byte_pos_next;
            crc_reg        <= crc_next;
            exp_slave_reg  <= exp_slave_next;
            exp_count_reg  <= exp_count_next;
            resp_slave_reg <= resp_slave_next;
            resp_func_reg  <= resp_func_next;
            resp_count_reg <= resp_count_next;
            pend_reg       <= pend_next;
            word_idx_reg   <= word_idx_next;
        end
    end

    a_tail_past_header: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mrr_pkg::PH_TAIL |-> byte_pos_reg >= 8'd3)
        else $error("tail phase entered before the header was complete");

endmodule

`default_nettype wire

FILE: rtl/mrr_queue.sv
// Short command queue that decouples the parser from the result sequencer.
// Uses mrr_pkg for the command type and depth.
`default_nettype none

module mrr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mrr_pkg::cmd_t wdata,
    output logic               full,
    input  wire logic          pop,
    output logic               rvalid,
    output mrr_pkg::cmd_t      rdata
);

    mrr_pkg::cmd_t          mem_reg [mrr_pkg::Q_DEPTH];
    logic [mrr_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mrr_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mrr_pkg::Q_AW:0]   count_reg, count_next;

    assign full   = (count_reg == (mrr_pkg::Q_AW + 1)'(mrr_pkg::Q_DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rvalid)
        else $error("command popped from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (mrr_pkg::Q_AW + 1)'(mrr_pkg::Q_DEPTH))
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

FILE: rtl/mrr_back.sv
// Back part: turns queued commands into result items, serializing the request frame and
// its CRC into a registered output one byte per cycle unless it stalls. Uses mrr_pkg.
`default_nettype none

module mrr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire mrr_pkg::cmd_t q_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output mrr_pkg::out_item_t out_item
);

    logic [2:0]         step_reg, step_next;
    logic [15:0]        tx_crc_reg, tx_crc_next;
    logic               out_valid_reg, out_valid_next;
    mrr_pkg::out_item_t out_reg, out_next;

    mrr_pkg::out_item_t res;
    logic               can_load;
    logic               advance;
    logic [15:0]        crc_in;
    logic [15:0]        crc_upd;

    assign can_load = !out_valid_reg || out_ready;
    assign advance  = q_valid && can_load;
    assign pop      = advance && res.last;

    always_comb
    begin
        res = '0;
        unique case (q_cmd.op)
            mrr_pkg::CMD_REQ:
            begin
                res.out_kind = mrr_pkg::OUT_TX;
                res.last     = (step_reg == 3'd7);
                unique case (step_reg)
                    3'd0: res.tx_byte = q_cmd.slave_id;
                    3'd1: res.tx_byte = mrr_pkg::FN_READ;
                    3'd2: res.tx_byte = q_cmd.word[15:8];
                    3'd3: res.tx_byte = q_cmd.word[7:0];
                    3'd4: res.tx_byte = 8'h00;
                    3'd5: res.tx_byte = {1'b0, q_cmd.index};
                    3'd6: res.tx_byte = tx_crc_reg[7:0];
                    default: res.tx_byte = tx_crc_reg[15:8];
                endcase
            end
            mrr_pkg::CMD_WORD:
            begin
                res.out_kind  = mrr_pkg::OUT_WORD;
                res.reg_index = q_cmd.index;
                res.reg_value = q_cmd.word;
                res.last      = 1'b1;
            end
            default:
            begin
                res.out_kind       = mrr_pkg::OUT_STATUS;
                res.status         = q_cmd.status;
                res.exception_code = q_cmd.exc;
                res.last           = 1'b1;
            end
        endcase
    end

    assign crc_in  = (step_reg == 3'd0) ? mrr_pkg::CRC_INIT : tx_crc_reg;
    assign crc_upd = mrr_pkg::crc_byte(crc_in, res.tx_byte);

    always_comb
    begin
        step_next      = step_reg;
        tx_crc_next    = tx_crc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (can_load)
        begin
            out_valid_next = q_valid;
        end
        if (advance)
        begin
            out_next  = res;
            step_next = res.last ? 3'd0 : step_reg + 3'd1;
            // fold the six header bytes into the frame CRC
            if (q_cmd.op == mrr_pkg::CMD_REQ && step_reg < 3'd6)
            begin
                tx_crc_next = crc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_crc_reg <= tx_crc_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_step_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != 3'd0 |-> q_valid && q_cmd.op == mrr_pkg::CMD_REQ)
        else $error("frame sequencer mid-request without a request at the queue head");

    a_single_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.out_kind != mrr_pkg::OUT_TX |-> out_reg.last)
        else $error("word or status result not marked last");

endmodule

`default_nettype wire
